FILE: design/rpq_pkg.sv
// Package with the shared constants, types and distance function of the palette quantizer.
package rpq_pkg;

  // Palette geometry and the colour index of the first entry.
  localparam int unsigned PaletteEntries = 208;
  localparam int unsigned FirstIndex     = 16;

  // Field widths.
  localparam int unsigned PixW  = 8;
  localparam int unsigned CompW = 6;
  localparam int unsigned IdxW  = 8;
  localparam int unsigned DistW = 18;

  // Cycles from an accepted quantize transaction to its result strobe.
  localparam int unsigned Latency = PaletteEntries + 1;

  // Operation codes.
  localparam logic OpWrite    = 1'b0;
  localparam logic OpQuantize = 1'b1;

  typedef logic [PixW-1:0]  pix_t;
  typedef logic [CompW-1:0] comp_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [DistW-1:0] dist_t;

  // Squared difference between a pixel component and four times a palette component.
  function automatic logic [2*PixW-1:0] sq_diff(input pix_t pix, input comp_t comp);
    logic [PixW-1:0] scaled;
    logic [PixW-1:0] d;
    scaled = {comp, 2'b00};
    d = (pix >= scaled) ? (pix - scaled) : (scaled - pix);
    return d * d;
  endfunction

endpackage

FILE: design/rgb_to_palette_quantizer.sv
// Top level of the palette quantizer: a systolic row of one compare cell per palette entry.
//
// Usage: one input channel (start_i with busy_o) carries transactions of two kinds.
// A write transaction (operation_i low) sets the palette entry named by entry_slot_i;
// slots outside 16..223 are ignored. A quantize transaction (operation_i high) returns
// one result on color_index_o and min_distance_o, marked by a
// one-cycle done_o strobe. Write transactions give no result.
// A transaction is accepted at every clock edge with start_i high, so the throughput is
// one transaction per cycle. The latency is set by the row of 208 cells, one register
// stage each, plus the input stage; each cell holds one palette entry, and a write
// travels down the row with the pixels so that every transaction sees the palette in
// the order in which the transactions were accepted.
// busy_o is always low. All entries must be written before the first quantize.
// Reset clears the valid bits of the stages, so pending transactions are dropped;
// the palette itself is not cleared. The receiver cannot stall, and none is needed.
module rgb_to_palette_quantizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                operation_i,
  input  rpq_pkg::pix_t       pixel_red_i,
  input  rpq_pkg::pix_t       pixel_green_i,
  input  rpq_pkg::pix_t       pixel_blue_i,
  input  rpq_pkg::idx_t       entry_slot_i,
  input  rpq_pkg::comp_t      entry_red_i,
  input  rpq_pkg::comp_t      entry_green_i,
  input  rpq_pkg::comp_t      entry_blue_i,
  output logic                done_o,
  output rpq_pkg::idx_t       color_index_o,
  output rpq_pkg::dist_t      min_distance_o
);
  import rpq_pkg::*;

  localparam int unsigned N = PaletteEntries;

  // Stage registers; index k feeds cell k, index N is the result stage.
  logic  valid_q [N+1];
  logic  op_q    [N+1];
  pix_t  pr_q    [N+1];
  pix_t  pg_q    [N+1];
  pix_t  pb_q    [N+1];
  idx_t  slot_q  [N+1];
  comp_t er_q    [N+1];
  comp_t eg_q    [N+1];
  comp_t eb_q    [N+1];
  dist_t best_q  [N+1];
  idx_t  bidx_q  [N+1];

  // Palette registers, one per cell; undefined until written.
  comp_t pal_r_q [N];
  comp_t pal_g_q [N];
  comp_t pal_b_q [N];

  assign busy_o = 1'b0;

  // Input stage captures each transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q[0]   <= operation_i;
    pr_q[0]   <= pixel_red_i;
    pg_q[0]   <= pixel_green_i;
    pb_q[0]   <= pixel_blue_i;
    slot_q[0] <= entry_slot_i;
    er_q[0]   <= entry_red_i;
    eg_q[0]   <= entry_green_i;
    eb_q[0]   <= entry_blue_i;
    best_q[0] <= '0;
    bidx_q[0] <= idx_t'(FirstIndex);
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    localparam idx_t CellIdx = idx_t'(FirstIndex + k);
    dist_t cell_dist;
    logic  take;

    // Distance from the pixel to this cell's entry; the first cell always takes it.
    always_comb begin
      cell_dist = dist_t'(sq_diff(pr_q[k], pal_r_q[k]))
                + dist_t'(sq_diff(pg_q[k], pal_g_q[k]))
                + dist_t'(sq_diff(pb_q[k], pal_b_q[k]));
      take = (k == 0) || (cell_dist <= best_q[k]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    // Pass the transaction on and keep the running best.
    always_ff @(posedge clk_i) begin
      op_q[k+1]   <= op_q[k];
      pr_q[k+1]   <= pr_q[k];
      pg_q[k+1]   <= pg_q[k];
      pb_q[k+1]   <= pb_q[k];
      slot_q[k+1] <= slot_q[k];
      er_q[k+1]   <= er_q[k];
      eg_q[k+1]   <= eg_q[k];
      eb_q[k+1]   <= eb_q[k];
      best_q[k+1] <= take ? cell_dist : best_q[k];
      bidx_q[k+1] <= take ? CellIdx : bidx_q[k];
    end

    // A write updates the entry when it passes its own cell.
    always_ff @(posedge clk_i) begin
      if (valid_q[k] && op_q[k] == OpWrite && slot_q[k] == CellIdx) begin
        pal_r_q[k] <= er_q[k];
        pal_g_q[k] <= eg_q[k];
        pal_b_q[k] <= eb_q[k];
      end
    end
  end

  // Results leave from the last stage.
  assign done_o         = valid_q[N] && (op_q[N] == OpQuantize);
  assign color_index_o  = bidx_q[N];
  assign min_distance_o = best_q[N];

endmodule

FILE: design/rpq_checker.sv
// Port-level checker for the palette quantizer, bound to the top level.
module rpq_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           operation_i,
  input rpq_pkg::idx_t  color_index_o,
  input rpq_pkg::dist_t min_distance_o,
  input logic           done_o
);
  import rpq_pkg::*;

  // Every result answers a quantize transaction accepted earlier.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o && operation_i == OpQuantize, Latency))
    else $error("result without a matching quantize transaction");

  // A result index lies within the palette.
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (color_index_o >= idx_t'(FirstIndex)
             && color_index_o <= idx_t'(FirstIndex + PaletteEntries - 1)))
    else $error("result index outside the palette");

  // The distance never exceeds three full-scale squared differences.
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (min_distance_o <= dist_t'(195075)))
    else $error("result distance out of range");

endmodule

bind rgb_to_palette_quantizer rpq_checker u_rpq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .operation_i    (operation_i),
  .color_index_o  (color_index_o),
  .min_distance_o (min_distance_o),
  .done_o         (done_o)
);
